/* design/merge_axis_phase_schedules_unit_assert.svh */
// assertion macros used by the checker file
// each macro states one clocked property, disabled while reset is low
`ifndef MERGE_AXIS_PHASE_SCHEDULES_UNIT_ASSERT_SVH
`define MERGE_AXIS_PHASE_SCHEDULES_UNIT_ASSERT_SVH

// same-cycle implication
`define MAPS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("maps assertion failed");

// next-cycle implication
`define MAPS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("maps assertion failed");

`endif

/* design/maps_pkg.sv */
// ----------------------------------------------------------------------------
// maps_pkg: shared types and constants of the phase schedule merger
// operation codes, sequencer states, store geometry and the result record
// ----------------------------------------------------------------------------
package maps_pkg;

  // store geometry
  localparam int AXIS_PHASES   = 4;
  localparam int MERGED_PHASES = 6;
  localparam int RESULT_LIMIT  = 6;
  localparam int RESULT_CAP    = (MERGED_PHASES < RESULT_LIMIT) ? MERGED_PHASES
                                                                : RESULT_LIMIT;
  localparam int AXIS_IDX_W    = (AXIS_PHASES > 1) ? $clog2(AXIS_PHASES) : 1;
  localparam int AXIS_CNT_W    = $clog2(AXIS_PHASES + 1);
  localparam int ROUND_W       = $clog2(MERGED_PHASES + 1);
  localparam int EMIT_W        = $clog2(RESULT_CAP + 1);
  localparam int PHASE_W       = 64;

  // configuration
  localparam int              CFG_IDX_W     = 1;
  localparam logic [CFG_IDX_W-1:0] REG_EPSILON = 1'b0;
  localparam logic [15:0]     EPSILON_RESET = 16'd7;

  typedef enum logic [1:0] {
    OP_LOAD_X = 2'd0,
    OP_LOAD_Y = 2'd1,
    OP_MERGE  = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FETCH,
    ST_STEP,
    ST_EMPTY
  } state_t;

  typedef struct packed {
    op_t         op;
    logic [31:0] dur;
    logic [31:0] acc;
  } item_t;

  typedef struct packed {
    logic [31:0] dur;
    logic [31:0] ax;
    logic [31:0] ay;
    logic        last;
    logic        dropped;
    logic        empty;
  } result_t;

endpackage

/* design/maps_ram.sv */
// ----------------------------------------------------------------------------
// maps_ram: simple dual-port phase store
// one write port, one read port with registered read data
// ----------------------------------------------------------------------------
module maps_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 4
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* design/maps_engine.sv */
// ----------------------------------------------------------------------------
// maps_engine: load and merge sequencer around the two phase stores
// loads fill free entries; a non-empty merge alternates fetch and step states
// ----------------------------------------------------------------------------
module maps_engine (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               item_valid,
  output logic               item_ready,
  input  maps_pkg::item_t    item,
  input  logic [15:0]        epsilon,
  output logic               res_valid,
  input  logic               res_ready,
  output maps_pkg::result_t  res
);

  localparam int CW = maps_pkg::AXIS_CNT_W;
  localparam int AW = maps_pkg::AXIS_IDX_W;
  localparam int RW = maps_pkg::ROUND_W;
  localparam int EW = maps_pkg::EMIT_W;

  maps_pkg::state_t state_r, state_nxt;
  logic [CW-1:0] xc_r, xc_nxt, yc_r, yc_nxt;
  logic [CW-1:0] px_r, px_nxt, py_r, py_nxt;
  logic [RW-1:0] round_r, round_nxt;
  logic [EW-1:0] emitted_r, emitted_nxt;
  logic [31:0]   remx_r, remx_nxt, remy_r, remy_nxt;
  logic          ovf_r, ovf_nxt;

  logic          wr_x, wr_y;
  logic [maps_pkg::PHASE_W-1:0] x_rdata, y_rdata;
  logic [31:0]   xd, xa, yd, ya, eps32;

  // step datapath
  logic          pair_mode, yflush_mode;
  logic [31:0]   tx, ty, diff;
  logic [32:0]   sum;
  logic [31:0]   st_dur, st_ax, st_ay, st_remx, st_remy;
  logic [CW-1:0] st_px, st_py;
  logic [RW-1:0] st_round;
  logic [EW-1:0] st_emitted;
  logic          st_more, st_final;

  // phase stores: {accel, duration}
  maps_ram #(.WIDTH(maps_pkg::PHASE_W), .DEPTH(maps_pkg::AXIS_PHASES)) u_x_ram (
    .clk   (clk),
    .we    (wr_x),
    .waddr (xc_r[AW-1:0]),
    .wdata ({item.acc, item.dur}),
    .raddr (px_r[AW-1:0]),
    .rdata (x_rdata)
  );

  maps_ram #(.WIDTH(maps_pkg::PHASE_W), .DEPTH(maps_pkg::AXIS_PHASES)) u_y_ram (
    .clk   (clk),
    .we    (wr_y),
    .waddr (yc_r[AW-1:0]),
    .wdata ({item.acc, item.dur}),
    .raddr (py_r[AW-1:0]),
    .rdata (y_rdata)
  );

  assign xd    = x_rdata[31:0];
  assign xa    = x_rdata[63:32];
  assign yd    = y_rdata[31:0];
  assign ya    = y_rdata[63:32];
  assign eps32 = {16'd0, epsilon};

  // one merge step on the fetched entries
  always_comb begin
    pair_mode   = (round_r < RW'(maps_pkg::MERGED_PHASES)) && (px_r < xc_r) &&
                  (py_r < yc_r);
    yflush_mode = !pair_mode && (py_r < yc_r);
    tx          = (remx_r > eps32) ? remx_r : xd;
    ty          = (remy_r > eps32) ? remy_r : yd;
    diff        = (tx > ty) ? (tx - ty) : (ty - tx);
    sum         = {1'b0, tx} + {1'b0, ty};
    st_px       = px_r;
    st_py       = py_r;
    st_round    = round_r;
    st_remx     = remx_r;
    st_remy     = remy_r;
    st_ax       = xa;
    st_ay       = ya;
    priority if (pair_mode) begin
      st_round = round_r + RW'(1);
      priority if (diff < eps32) begin
        st_dur  = sum[32:1];
        st_remx = '0;
        st_remy = '0;
        st_px   = px_r + CW'(1);
        st_py   = py_r + CW'(1);
      end else if (tx < ty) begin
        st_dur  = tx;
        st_remx = '0;
        st_remy = ty - tx;
        st_px   = px_r + CW'(1);
      end else begin
        st_dur  = ty;
        st_remx = tx - ty;
        st_remy = '0;
        st_py   = py_r + CW'(1);
      end
    end else if (yflush_mode) begin
      st_dur  = ty;
      st_remy = '0;
      st_ax   = '0;
      st_py   = py_r + CW'(1);
    end else begin
      st_dur  = tx;
      st_remx = '0;
      st_ay   = '0;
      st_px   = px_r + CW'(1);
    end
    st_emitted = emitted_r + EW'(1);
    st_more    = (st_px < xc_r) || (st_py < yc_r);
    st_final   = !st_more || (st_emitted == EW'(maps_pkg::RESULT_CAP));
  end

  // state and counter registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= maps_pkg::ST_IDLE;
      xc_r      <= '0;
      yc_r      <= '0;
      px_r      <= '0;
      py_r      <= '0;
      round_r   <= '0;
      emitted_r <= '0;
      remx_r    <= '0;
      remy_r    <= '0;
      ovf_r     <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      xc_r      <= xc_nxt;
      yc_r      <= yc_nxt;
      px_r      <= px_nxt;
      py_r      <= py_nxt;
      round_r   <= round_nxt;
      emitted_r <= emitted_nxt;
      remx_r    <= remx_nxt;
      remy_r    <= remy_nxt;
      ovf_r     <= ovf_nxt;
    end
  end

  // next state and outputs
  always_comb begin
    state_nxt   = state_r;
    xc_nxt      = xc_r;
    yc_nxt      = yc_r;
    px_nxt      = px_r;
    py_nxt      = py_r;
    round_nxt   = round_r;
    emitted_nxt = emitted_r;
    remx_nxt    = remx_r;
    remy_nxt    = remy_r;
    ovf_nxt     = ovf_r;
    item_ready  = (state_r == maps_pkg::ST_IDLE);
    wr_x        = 1'b0;
    wr_y        = 1'b0;
    res_valid   = 1'b0;
    res         = '0;
    unique case (state_r)
      maps_pkg::ST_IDLE: begin
        if (item_valid) begin
          unique case (item.op)
            maps_pkg::OP_LOAD_X: begin
              if (xc_r < CW'(maps_pkg::AXIS_PHASES)) begin
                wr_x   = 1'b1;
                xc_nxt = xc_r + CW'(1);
              end else begin
                ovf_nxt = 1'b1;
              end
            end
            maps_pkg::OP_LOAD_Y: begin
              if (yc_r < CW'(maps_pkg::AXIS_PHASES)) begin
                wr_y   = 1'b1;
                yc_nxt = yc_r + CW'(1);
              end else begin
                ovf_nxt = 1'b1;
              end
            end
            maps_pkg::OP_MERGE: begin
              px_nxt      = '0;
              py_nxt      = '0;
              round_nxt   = '0;
              emitted_nxt = '0;
              remx_nxt    = '0;
              remy_nxt    = '0;
              if (xc_r == '0 && yc_r == '0) begin
                state_nxt = maps_pkg::ST_EMPTY;
              end else begin
                state_nxt = maps_pkg::ST_FETCH;
              end
            end
            maps_pkg::OP_NONE: begin
            end
          endcase
        end
      end
      maps_pkg::ST_FETCH: begin
        state_nxt = maps_pkg::ST_STEP;
      end
      maps_pkg::ST_STEP: begin
        if (res_ready) begin
          res_valid   = 1'b1;
          res.dur     = st_dur;
          res.ax      = st_ax;
          res.ay      = st_ay;
          res.last    = st_final;
          res.dropped = st_final && (ovf_r || st_more);
          px_nxt      = st_px;
          py_nxt      = st_py;
          round_nxt   = st_round;
          emitted_nxt = st_emitted;
          remx_nxt    = st_remx;
          remy_nxt    = st_remy;
          if (st_final) begin
            xc_nxt    = '0;
            yc_nxt    = '0;
            ovf_nxt   = 1'b0;
            state_nxt = maps_pkg::ST_IDLE;
          end else begin
            state_nxt = maps_pkg::ST_FETCH;
          end
        end
      end
      maps_pkg::ST_EMPTY: begin
        if (res_ready) begin
          res_valid = 1'b1;
          res.last  = 1'b1;
          res.empty = 1'b1;
          ovf_nxt   = 1'b0;
          state_nxt = maps_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = maps_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

/* design/merge_axis_phase_schedules_unit.sv */
// ----------------------------------------------------------------------------
// merge_axis_phase_schedules_unit: two-axis phase schedule merger
// loads are taken while idle; a merge runs the fetch and step loop over the stores'
// registered read and yields at most 6 phases
// reset: synchronous rst_n clears counts, flags, output valid, epsilon to 7
// ----------------------------------------------------------------------------
module merge_axis_phase_schedules_unit (
  input  logic         clk,
  input  logic         rst_n,
  // input stream
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [63:0]  in_tdata,   // phase_duration[31:0], phase_accel[63:32]
  input  logic [1:0]   in_tuser,   // operation[1:0]
  // result stream
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [95:0]  out_tdata,  // merged_duration, merged_accel_x, merged_accel_y
  output logic         out_tlast,  // last_phase
  output logic [1:0]   out_tuser,  // dropped[0], empty_run[1]
  // configuration port
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [2:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready
);

  logic [15:0]          eps_r;
  logic                 cfg_wr;
  logic [maps_pkg::CFG_IDX_W-1:0] cfg_idx;
  maps_pkg::item_t      item;
  maps_pkg::result_t    res;
  logic                 res_valid, res_ready;
  logic                 out_valid_r;
  maps_pkg::result_t    out_res_r;

  // register file
  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[2:2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = (cfg_idx == maps_pkg::REG_EPSILON) ? {16'd0, eps_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eps_r <= maps_pkg::EPSILON_RESET;
    end else if (cfg_wr && cfg_idx == maps_pkg::REG_EPSILON) begin
      eps_r <= cfg_pwdata[15:0];
    end
  end

  // input transfer unpacking
  assign item.op  = maps_pkg::op_t'(in_tuser);
  assign item.dur = in_tdata[31:0];
  assign item.acc = in_tdata[63:32];

  maps_engine u_engine (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (in_tvalid),
    .item_ready (in_tready),
    .item       (item),
    .epsilon    (eps_r),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res)
  );

  // output register, refilled in the cycle it drains
  assign res_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_res_r.ay, out_res_r.ax, out_res_r.dur};
  assign out_tlast  = out_res_r.last;
  assign out_tuser  = {out_res_r.empty, out_res_r.dropped};

endmodule

/* design/merge_axis_phase_schedules_unit_checker.sv */
// ----------------------------------------------------------------------------
// merge_axis_phase_schedules_unit_checker: port-level checks of the merger
// result flags and stall behavior, bound to the top level
// ----------------------------------------------------------------------------
`include "merge_axis_phase_schedules_unit_assert.svh"

module merge_axis_phase_schedules_unit_checker (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [1:0]   in_tuser,
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [95:0]  out_tdata,
  input  logic         out_tlast,
  input  logic [1:0]   out_tuser
);

  // a stalled result holds
  `MAPS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready,
                    out_tvalid && $stable(out_tdata) && $stable(out_tlast) &&
                    $stable(out_tuser))

  // an empty run is a lone zero result closing the run
  `MAPS_ASSERT_NOW(a_empty_run, clk, rst_n, out_tvalid && out_tuser[1],
                   out_tlast && (out_tdata == 96'd0) && !out_tuser[0])

  // the drop flag rides only on the closing result
  `MAPS_ASSERT_NOW(a_drop_last, clk, rst_n, out_tvalid && out_tuser[0], out_tlast)

  // a non-merge command with the output idle raises no result next cycle
  `MAPS_ASSERT_NEXT(a_load_silent, clk, rst_n,
                    in_tvalid && in_tready && (in_tuser != maps_pkg::OP_MERGE) &&
                    !out_tvalid, !out_tvalid)

endmodule

bind merge_axis_phase_schedules_unit merge_axis_phase_schedules_unit_checker u_checker (.*);

/* bench/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench of the two-axis phase schedule merger
// sends load and merge commands on the input stream, computes every merged
// phase in a behavioral model of the merger and compares the result stream
// field by field, under random source bursts, sink stalls and epsilon changes
// ----------------------------------------------------------------------------
module tb;

  localparam int         RANDOM_ITEMS  = 340;
  localparam int         SETTLE_CYCLES = 24;
  localparam int         QUIET_LIMIT   = 5000;
  localparam logic [2:0] EPSILON_ADDR  = {maps_pkg::REG_EPSILON, 2'b00};

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [63:0] in_tdata;     // phase_duration[31:0], phase_accel[63:32]
  logic [1:0]  in_tuser;     // operation[1:0]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [95:0] out_tdata;    // merged_duration, merged_accel_x, merged_accel_y
  logic        out_tlast;    // last_phase
  logic [1:0]  out_tuser;    // dropped[0], empty_run[1]
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [2:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  merge_axis_phase_schedules_unit u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .out_tuser   (out_tuser),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // clock, 4 ns period
  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // model of the merger state
  logic [31:0] x_dur_mem [maps_pkg::AXIS_PHASES];
  logic [31:0] x_acc_mem [maps_pkg::AXIS_PHASES];
  logic [31:0] y_dur_mem [maps_pkg::AXIS_PHASES];
  logic [31:0] y_acc_mem [maps_pkg::AXIS_PHASES];
  int unsigned x_loaded;
  int unsigned y_loaded;
  bit          load_lost;
  logic [15:0] eps_model;

  maps_pkg::result_t merged_phase_q [$];
  int unsigned fail_count;
  int unsigned burst_left;
  int unsigned random_sent;
  int unsigned ready_run = 0;
  int unsigned stall_run = 0;
  int unsigned quiet_cycles = 0;

  // walk both schedules and queue the merged phases
  function automatic void merge_schedules();
    maps_pkg::result_t run [$];
    maps_pkg::result_t ph;
    logic [31:0] rem_x, rem_y, tx, ty, diff;
    logic [32:0] sum;
    int unsigned px, py, rnd;
    bit          lost;
    rem_x = '0;
    rem_y = '0;
    px    = 0;
    py    = 0;
    rnd   = 0;
    lost  = 1'b0;
    ph    = '0;
    // both stores empty
    if (x_loaded == 0 && y_loaded == 0) begin
      ph.last  = 1'b1;
      ph.empty = 1'b1;
      merged_phase_q.insert(merged_phase_q.size(), ph);
      load_lost = 1'b0;
      return;
    end
    // paired walk
    while (rnd < maps_pkg::MERGED_PHASES && px < x_loaded && py < y_loaded) begin
      tx    = (rem_x > eps_model) ? rem_x : x_dur_mem[px];
      ty    = (rem_y > eps_model) ? rem_y : y_dur_mem[py];
      diff  = (tx > ty) ? tx - ty : ty - tx;
      ph    = '0;
      ph.ax = x_acc_mem[px];
      ph.ay = y_acc_mem[py];
      if (diff < eps_model) begin
        sum    = {1'b0, tx} + {1'b0, ty};
        ph.dur = sum[32:1];
        rem_x  = '0;
        rem_y  = '0;
        px++;
        py++;
      end else if (tx < ty) begin
        ph.dur = tx;
        rem_x  = '0;
        rem_y  = ty - tx;
        px++;
      end else begin
        ph.dur = ty;
        rem_x  = tx - ty;
        rem_y  = '0;
        py++;
      end
      run.insert(run.size(), ph);
      rnd++;
    end
    // flush y, then x
    while (py < y_loaded) begin
      ph     = '0;
      ph.dur = (rem_y > eps_model) ? rem_y : y_dur_mem[py];
      ph.ay  = y_acc_mem[py];
      rem_y  = '0;
      run.insert(run.size(), ph);
      py++;
    end
    while (px < x_loaded) begin
      ph     = '0;
      ph.dur = (rem_x > eps_model) ? rem_x : x_dur_mem[px];
      ph.ax  = x_acc_mem[px];
      rem_x  = '0;
      run.insert(run.size(), ph);
      px++;
    end
    // phases past the output cap are lost
    while (run.size() > maps_pkg::RESULT_CAP) begin
      void'(run.pop_back());
      lost = 1'b1;
    end
    run[run.size()-1].last    = 1'b1;
    run[run.size()-1].dropped = load_lost || lost;
    foreach (run[i]) merged_phase_q.insert(merged_phase_q.size(), run[i]);
    x_loaded  = 0;
    y_loaded  = 0;
    load_lost = 1'b0;
  endfunction

  // apply one accepted command to the model
  function automatic void predict_command(maps_pkg::op_t op, logic [31:0] dur,
                                          logic [31:0] acc);
    case (op)
      maps_pkg::OP_LOAD_X: begin
        if (x_loaded < maps_pkg::AXIS_PHASES) begin
          x_dur_mem[x_loaded] = dur;
          x_acc_mem[x_loaded] = acc;
          x_loaded++;
        end else begin
          load_lost = 1'b1;
        end
      end
      maps_pkg::OP_LOAD_Y: begin
        if (y_loaded < maps_pkg::AXIS_PHASES) begin
          y_dur_mem[y_loaded] = dur;
          y_acc_mem[y_loaded] = acc;
          y_loaded++;
        end else begin
          load_lost = 1'b1;
        end
      end
      maps_pkg::OP_MERGE: begin
        merge_schedules();
      end
      default: begin
      end
    endcase
  endfunction

  // one input transfer, sent in bursts with random gaps
  task automatic send_command(maps_pkg::op_t op, logic [31:0] dur, logic [31:0] acc);
    @(negedge clk);
    if (burst_left == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
                                               : $urandom_range(1, 10);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {acc, dur};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_command(op, dur, acc);
    burst_left--;
  endtask

  // source goes quiet until every merged phase has arrived
  task automatic hold_until_drained();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (merged_phase_q.size() != 0) @(posedge clk);
  endtask

  // write epsilon while idle and read it back
  task automatic write_epsilon(logic [15:0] value);
    hold_until_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr   <= EPSILON_ADDR;
    cfg_pwdata  <= {16'h0000, value};
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    eps_model = value;
    @(negedge clk);
    cfg_pwrite  <= 1'b0;
    cfg_penable <= 1'b0;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    if (cfg_prdata !== {16'h0000, eps_model}) begin
      $error("epsilon readback expected %h actual %h", {16'h0000, eps_model}, cfg_prdata);
      fail_count++;
    end
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  // durations: mostly short, some close to a neighbor, some extreme or wide
  function automatic logic [31:0] pick_duration(logic [31:0] near);
    case ($urandom_range(0, 7))
      0:       return $urandom();
      1, 2:    return near + $urandom_range(0, 2 * eps_model + 2) - eps_model - 1;
      3: begin
        case ($urandom_range(0, 2))
          0:       return 32'h0000_0000;
          1:       return 32'hFFFF_FFFF;
          default: return 32'h8000_0000;
        endcase
      end
      default: return $urandom_range(1, 400);
    endcase
  endfunction

  function automatic logic [31:0] pick_accel();
    if ($urandom_range(0, 7) != 0) return $urandom();
    case ($urandom_range(0, 3))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'h0000_0000;
      default: return 32'hFFFF_FFFF;
    endcase
  endfunction

  function automatic logic [15:0] pick_epsilon();
    case ($urandom_range(0, 4))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return 16'($urandom_range(0, 32));
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  // random loads for both axes, some overfilled, with noise, then a merge
  task automatic run_random_sequence();
    int unsigned nx, ny;
    logic [31:0] near, dur;
    nx   = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 6) : $urandom_range(0, 4);
    ny   = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 6) : $urandom_range(0, 4);
    near = $urandom_range(1, 400);
    while (nx + ny != 0) begin
      dur = pick_duration(near);
      if (nx != 0 && (ny == 0 || $urandom_range(0, 1) == 1)) begin
        send_command(maps_pkg::OP_LOAD_X, dur, pick_accel());
        nx--;
      end else begin
        send_command(maps_pkg::OP_LOAD_Y, dur, pick_accel());
        ny--;
      end
      near = dur;
      random_sent++;
      if ($urandom_range(0, 15) == 0) begin
        send_command(maps_pkg::OP_NONE, $urandom(), $urandom());
      end
    end
    send_command(maps_pkg::OP_MERGE, $urandom(), $urandom());
    random_sent++;
  endtask

  task automatic test_empty_merge();
    send_command(maps_pkg::OP_MERGE, 32'hFFFF_FFFF, 32'h8000_0000);
  endtask

  // largest durations averaged through the 33-bit sum, extreme accelerations
  task automatic test_field_extremes();
    send_command(maps_pkg::OP_LOAD_X, 32'hFFFF_FFFF, 32'h8000_0000);
    send_command(maps_pkg::OP_LOAD_Y, 32'hFFFF_FFFE, 32'h7FFF_FFFF);
    send_command(maps_pkg::OP_MERGE, 32'h0000_0000, 32'h0000_0000);
  endtask

  // full x store, an ignored command, x-only flush
  task automatic test_store_overflow();
    send_command(maps_pkg::OP_LOAD_X, 32'h0000_0000, 32'hFFFF_FFFF);
    send_command(maps_pkg::OP_LOAD_X, 32'h0000_0001, 32'h0000_0001);
    send_command(maps_pkg::OP_NONE, 32'h5555_5555, 32'hAAAA_AAAA);
    send_command(maps_pkg::OP_LOAD_X, 32'h8000_0000, 32'h8000_0000);
    send_command(maps_pkg::OP_LOAD_X, 32'h0000_3039, 32'h7FFF_FFFF);
    send_command(maps_pkg::OP_LOAD_X, 32'h0000_0007, 32'h1234_5678);
    send_command(maps_pkg::OP_MERGE, 32'h0, 32'h0);
  endtask

  // staggered schedules give more merged phases than the output holds
  task automatic test_phase_limit();
    send_command(maps_pkg::OP_LOAD_X, 32'd100, 32'h0001_0000);
    send_command(maps_pkg::OP_LOAD_Y, 32'd60,  32'hFFFF_0000);
    send_command(maps_pkg::OP_LOAD_X, 32'd30,  32'h0002_0000);
    send_command(maps_pkg::OP_LOAD_Y, 32'd60,  32'hFFFE_0000);
    send_command(maps_pkg::OP_LOAD_X, 32'd0,   32'h0003_0000);
    send_command(maps_pkg::OP_LOAD_Y, 32'd62,  32'hFFFD_0000);
    send_command(maps_pkg::OP_LOAD_X, 32'd250, 32'h0004_0000);
    send_command(maps_pkg::OP_LOAD_Y, 32'd200, 32'hFFFC_0000);
    send_command(maps_pkg::OP_MERGE, 32'h0, 32'h0);
  endtask

  // zero tolerance, then the widest tolerance, then back to reset value
  task automatic test_epsilon_extremes();
    write_epsilon(16'h0000);
    send_command(maps_pkg::OP_LOAD_X, 32'd100, 32'h0000_1111);
    send_command(maps_pkg::OP_LOAD_Y, 32'd100, 32'h0000_2222);
    send_command(maps_pkg::OP_MERGE, 32'h0, 32'h0);
    write_epsilon(16'hFFFF);
    send_command(maps_pkg::OP_LOAD_X, 32'd100,   32'h0000_3333);
    send_command(maps_pkg::OP_LOAD_Y, 32'd60000, 32'h0000_4444);
    send_command(maps_pkg::OP_MERGE, 32'h0, 32'h0);
    write_epsilon(maps_pkg::EPSILON_RESET);
  endtask

  task automatic test_random_schedules();
    int unsigned seq;
    seq = 0;
    while (random_sent < RANDOM_ITEMS) begin
      if (seq % 12 == 11) write_epsilon(pick_epsilon());
      if (seq % 9 == 4) hold_until_drained();
      run_random_sequence();
      seq++;
    end
    write_epsilon(16'hFFFF);
    run_random_sequence();
    write_epsilon(16'h0000);
    run_random_sequence();
  endtask

  // sink stalls: ready stretches, some long, broken by stalls
  always @(negedge clk) begin
    if (ready_run != 0) begin
      out_tready <= 1'b1;
      ready_run--;
    end else if (stall_run != 0) begin
      out_tready <= 1'b0;
      stall_run--;
    end else begin
      ready_run = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 80)
                                              : $urandom_range(1, 6);
      stall_run = $urandom_range(1, 8);
      out_tready <= 1'b1;
    end
  end

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s expected %h actual %h", name, want, got);
      fail_count++;
    end
  endfunction

  // compare each result transfer with the oldest merged phase
  always @(posedge clk) begin : check_result
    maps_pkg::result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (merged_phase_q.size() == 0) begin
        $error("result transfer with no merged phase pending");
        fail_count++;
      end else begin
        want = merged_phase_q.pop_front();
        check_field("merged_duration", want.dur, out_tdata[31:0]);
        check_field("merged_accel_x", want.ax, out_tdata[63:32]);
        check_field("merged_accel_y", want.ay, out_tdata[95:64]);
        check_field("last_phase", 32'(want.last), 32'(out_tlast));
        check_field("dropped", 32'(want.dropped), 32'(out_tuser[0]));
        check_field("empty_run", 32'(want.empty), 32'(out_tuser[1]));
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_psel && cfg_penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tuser    = maps_pkg::OP_NONE;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    x_loaded    = 0;
    y_loaded    = 0;
    load_lost   = 1'b0;
    eps_model   = maps_pkg::EPSILON_RESET;
    fail_count  = 0;
    burst_left  = 0;
    random_sent = 0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    test_empty_merge();
    test_field_extremes();
    test_store_overflow();
    test_phase_limit();
    test_epsilon_extremes();
    test_random_schedules();

    hold_until_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0 && merged_phase_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+design
design/maps_pkg.sv
design/maps_ram.sv
design/maps_engine.sv
design/merge_axis_phase_schedules_unit.sv
design/merge_axis_phase_schedules_unit_checker.sv
bench/tb.sv
